FILE: rtl/vbch_pkg.sv
package vbch_pkg;

  localparam int SMP_W     = 16;
  localparam int OUT_W     = 24;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int X_W       = 27;
  localparam int MAG_W     = 26;
  localparam int ENV_W     = 26;
  localparam int RATIO_W   = 24;
  localparam int SUM_W     = 32;
  localparam int ACC_W     = 52;
  localparam int MA_W      = 32;
  localparam int MB_W      = 25;
  localparam int DEN_W     = 31;
  localparam int NUM_W     = 48;
  localparam int DIV_CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME  = CFG_IDX_W'(3);

  localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd7;
  localparam logic [COEF_W-1:0] RELEASE_RST = 16'd65529;
  localparam logic [COEF_W-1:0] GAIN_RST    = 16'd4506;
  localparam logic [COEF_W-1:0] VOLUME_RST  = 16'd1358;

  // -2.2 in q11.14, folded negation
  localparam logic signed [MB_W-1:0] SCALE_NEG      = -25'sd36045;
  localparam logic signed [MB_W-1:0] HARM_FALL      = 25'sd5384;
  localparam logic signed [MB_W-1:0] HARM_RISE      = 25'sd819;
  localparam logic signed [MB_W-1:0] HARM_FALL_KEEP = 25'sd60152;
  localparam logic signed [MB_W-1:0] HARM_RISE_KEEP = 25'sd64717;

  localparam logic [DEN_W-1:0] ENV_ONE      = DEN_W'(32'd16777216);
  localparam logic [DEN_W-1:0] ENV_SLOPE    = DEN_W'(14);
  localparam logic [NUM_W-1:0] RATIO_NUM    = {4'd15, 44'd0};
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(RATIO_W);

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_in;
    logic                    last_in_block;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample_out;
    logic                    last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    MAC_SCALE,
    MAC_ENV_OLD,
    MAC_ENV_NEW,
    MAC_HARM_OLD,
    MAC_HARM_NEW,
    MAC_RATIO,
    MAC_GAIN,
    MAC_VOL
  } mac_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_XREG,
    ST_ENV_A,
    ST_ENV_B,
    ST_ENV_W,
    ST_HARM_A,
    ST_HARM_B,
    ST_HARM_W,
    ST_DIV_WAIT,
    ST_RATIO,
    ST_GAIN,
    ST_SUM_W,
    ST_VOL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     mac_en;
    logic     mac_clr;
    mac_sel_t mac_sel;
    logic     x_wr;
    logic     env_wr;
    logic     harm_wr;
    logic     sum_wr;
    logic     div_start;
    logic     out_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

  // rounding offset preloaded ahead of each product chain
  function automatic logic [ACC_W-1:0] mac_round(mac_sel_t sel);
    logic [ACC_W-1:0] r;
    unique case (sel)
      MAC_SCALE:    r = ACC_W'(1) << 4;
      MAC_ENV_OLD:  r = ACC_W'(1) << 15;
      MAC_HARM_OLD: r = ACC_W'(1) << 15;
      MAC_RATIO:    r = ACC_W'(1) << 19;
      MAC_VOL:      r = ACC_W'(1) << 17;
      MAC_ENV_NEW,
      MAC_HARM_NEW,
      MAC_GAIN:     r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/vbch_div.sv
module vbch_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [vbch_pkg::ENV_W-1:0]         env,
  output logic                               busy,
  output logic [vbch_pkg::RATIO_W-1:0]       quo
);

  localparam int DW = vbch_pkg::DEN_W;
  localparam int QW = vbch_pkg::RATIO_W;
  localparam int NW = vbch_pkg::NUM_W;

  logic [DW-1:0]                    den_r, den_nxt;
  logic [DW-1:0]                    rem_r, rem_nxt;
  logic [QW-1:0]                    num_r, num_nxt;
  logic [vbch_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [DW-1:0] den_start;
  logic [NW-1:0] num_start;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    den_start = vbch_pkg::ENV_ONE + ({{(DW-vbch_pkg::ENV_W){1'b0}}, env} * vbch_pkg::ENV_SLOPE);
    num_start = vbch_pkg::RATIO_NUM + {{(NW-DW+1){1'b0}}, den_start[DW-1:1]};
    trial     = {rem_r, num_r[QW-1]};
    diff      = trial - {1'b0, den_r};
    ge        = trial >= {1'b0, den_r};
  end

  always_comb begin
    den_nxt = den_r;
    rem_nxt = rem_r;
    num_nxt = num_r;
    cnt_nxt = cnt_r;
    priority if (start) begin
      den_nxt = den_start;
      rem_nxt = {{(DW-(NW-QW)){1'b0}}, num_start[NW-1:QW]};
      num_nxt = num_start[QW-1:0];
      cnt_nxt = vbch_pkg::DIV_STEPS;
    end else if (cnt_r != '0) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      num_nxt = {num_r[QW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo  = num_r;

endmodule

FILE: rtl/vbch_dp.sv
module vbch_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vbch_pkg::dp_cmd_t                   cmd,
  output vbch_pkg::dp_sts_t                   sts,
  input  vbch_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [vbch_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vbch_pkg::COEF_W-1:0]         cfg_data,
  output vbch_pkg::out_item_t                 out_data
);

  localparam int XW = vbch_pkg::X_W;
  localparam int EW = vbch_pkg::ENV_W;
  localparam int AW = vbch_pkg::ACC_W;
  localparam int MA = vbch_pkg::MA_W;
  localparam int MB = vbch_pkg::MB_W;
  localparam int OW = vbch_pkg::OUT_W;
  localparam int CW = vbch_pkg::COEF_W;
  localparam int YW = AW - 18;

  logic [CW-1:0] attack_r, release_r, gain_r, volume_r;
  logic [CW-1:0] attack_nxt, release_nxt, gain_nxt, volume_nxt;

  logic signed [vbch_pkg::SMP_W-1:0] smp_r;
  logic                              last_r;
  logic signed [XW-1:0]              x_r;
  logic [vbch_pkg::MAG_W-1:0]        mag_r;
  logic [CW-1:0]                     c_r;
  logic                              fall_r;
  logic [EW-1:0]                     env_r, env_nxt;
  logic signed [XW-1:0]              harm_r, harm_nxt;
  logic signed [vbch_pkg::SUM_W-1:0] sum_r;
  logic [AW-1:0]                     acc_r, acc_nxt;
  vbch_pkg::out_item_t               out_r;

  logic signed [XW-1:0]              x_nxt;
  logic signed [XW-1:0]              x_neg;
  logic [vbch_pkg::MAG_W-1:0]        mag_nxt;
  logic [CW:0]                       env_keep;
  logic signed [MA-1:0]              mul_a;
  logic signed [MB-1:0]              mul_b;
  logic signed [MA+MB-1:0]           prod;
  logic [AW-1:0]                     acc_base;
  logic signed [YW-1:0]              y_full;
  logic signed [OW-1:0]              y_sat;
  logic [vbch_pkg::RATIO_W-1:0]      ratio;

  vbch_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .env   (env_r),
    .busy  (sts.div_busy),
    .quo   (ratio)
  );

  // configuration
  always_comb begin
    attack_nxt  = attack_r;
    release_nxt = release_r;
    gain_nxt    = gain_r;
    volume_nxt  = volume_r;
    if (cfg_we) begin
      unique case (cfg_index)
        vbch_pkg::REG_ATTACK:  attack_nxt  = cfg_data;
        vbch_pkg::REG_RELEASE: release_nxt = cfg_data;
        vbch_pkg::REG_GAIN:    gain_nxt    = cfg_data;
        vbch_pkg::REG_VOLUME:  volume_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiply-accumulate
  always_comb begin
    env_keep = {1'b1, {CW{1'b0}}} - {1'b0, c_r};
    unique case (cmd.mac_sel)
      vbch_pkg::MAC_SCALE: begin
        mul_a = {{(MA-vbch_pkg::SMP_W){smp_r[vbch_pkg::SMP_W-1]}}, smp_r};
        mul_b = vbch_pkg::SCALE_NEG;
      end
      vbch_pkg::MAC_ENV_OLD: begin
        mul_a = {{(MA-EW){1'b0}}, env_r};
        mul_b = {{(MB-CW-1){1'b0}}, env_keep};
      end
      vbch_pkg::MAC_ENV_NEW: begin
        mul_a = {{(MA-vbch_pkg::MAG_W){1'b0}}, mag_r};
        mul_b = {{(MB-CW){1'b0}}, c_r};
      end
      vbch_pkg::MAC_HARM_OLD: begin
        mul_a = {{(MA-XW){harm_r[XW-1]}}, harm_r};
        mul_b = fall_r ? vbch_pkg::HARM_FALL_KEEP : vbch_pkg::HARM_RISE_KEEP;
      end
      vbch_pkg::MAC_HARM_NEW: begin
        mul_a = {{(MA-XW){x_r[XW-1]}}, x_r};
        mul_b = fall_r ? vbch_pkg::HARM_FALL : vbch_pkg::HARM_RISE;
      end
      vbch_pkg::MAC_RATIO: begin
        mul_a = {{(MA-XW){x_r[XW-1]}}, x_r};
        mul_b = {{(MB-vbch_pkg::RATIO_W){1'b0}}, ratio};
      end
      vbch_pkg::MAC_GAIN: begin
        mul_a = {{(MA-XW){harm_r[XW-1]}}, harm_r};
        mul_b = {{(MB-CW-8){1'b0}}, gain_r, 8'd0};
      end
      vbch_pkg::MAC_VOL: begin
        mul_a = sum_r;
        mul_b = {{(MB-CW){1'b0}}, volume_r};
      end
    endcase
    prod     = mul_a * mul_b;
    acc_base = cmd.mac_clr ? vbch_pkg::mac_round(cmd.mac_sel) : acc_r;
    acc_nxt  = cmd.mac_en ? acc_base + prod[AW-1:0] : acc_r;
  end

  // sample, envelope and harmonic follower updates
  always_comb begin
    x_nxt    = acc_r[XW+4:5];
    x_neg    = -x_nxt;
    mag_nxt  = x_nxt[XW-1] ? x_neg[vbch_pkg::MAG_W-1:0] : x_nxt[vbch_pkg::MAG_W-1:0];
    env_nxt  = cmd.env_wr ? acc_r[EW+15:16] : env_r;
    harm_nxt = cmd.harm_wr ? acc_r[XW+15:16] : harm_r;
  end

  // output rounding and saturation
  always_comb begin
    y_full = acc_r[AW-1:18];
    priority if (!y_full[YW-1] && (|y_full[YW-2:OW-1])) begin
      y_sat = {1'b0, {(OW-1){1'b1}}};
    end else if (y_full[YW-1] && !(&y_full[YW-2:OW-1])) begin
      y_sat = {1'b1, {(OW-1){1'b0}}};
    end else begin
      y_sat = y_full[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= vbch_pkg::ATTACK_RST;
      release_r <= vbch_pkg::RELEASE_RST;
      gain_r    <= vbch_pkg::GAIN_RST;
      volume_r  <= vbch_pkg::VOLUME_RST;
      env_r     <= '0;
      harm_r    <= '0;
    end else begin
      attack_r  <= attack_nxt;
      release_r <= release_nxt;
      gain_r    <= gain_nxt;
      volume_r  <= volume_nxt;
      env_r     <= env_nxt;
      harm_r    <= harm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.load_in) begin
      smp_r  <= in_data.sample_in;
      last_r <= in_data.last_in_block;
    end
    if (cmd.x_wr) begin
      x_r    <= x_nxt;
      mag_r  <= mag_nxt;
      c_r    <= (mag_nxt > env_r) ? attack_r : release_r;
      fall_r <= x_nxt < harm_r;
    end
    if (cmd.sum_wr) begin
      sum_r <= acc_r[vbch_pkg::SUM_W+19:20];
    end
    if (cmd.out_wr) begin
      out_r.sample_out <= y_sat;
      out_r.last_out   <= last_r;
    end
  end

  assign out_data = out_r;

endmodule

FILE: rtl/vbch_ctrl.sv
module vbch_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  vbch_pkg::dp_sts_t sts,
  output vbch_pkg::dp_cmd_t cmd
);

  vbch_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vbch_pkg::ST_IDLE:     if (in_valid) state_nxt = vbch_pkg::ST_SCALE;
      vbch_pkg::ST_SCALE:    state_nxt = vbch_pkg::ST_XREG;
      vbch_pkg::ST_XREG:     state_nxt = vbch_pkg::ST_ENV_A;
      vbch_pkg::ST_ENV_A:    state_nxt = vbch_pkg::ST_ENV_B;
      vbch_pkg::ST_ENV_B:    state_nxt = vbch_pkg::ST_ENV_W;
      vbch_pkg::ST_ENV_W:    state_nxt = vbch_pkg::ST_HARM_A;
      vbch_pkg::ST_HARM_A:   state_nxt = vbch_pkg::ST_HARM_B;
      vbch_pkg::ST_HARM_B:   state_nxt = vbch_pkg::ST_HARM_W;
      vbch_pkg::ST_HARM_W:   state_nxt = vbch_pkg::ST_DIV_WAIT;
      vbch_pkg::ST_DIV_WAIT: if (!sts.div_busy) state_nxt = vbch_pkg::ST_RATIO;
      vbch_pkg::ST_RATIO:    state_nxt = vbch_pkg::ST_GAIN;
      vbch_pkg::ST_GAIN:     state_nxt = vbch_pkg::ST_SUM_W;
      vbch_pkg::ST_SUM_W:    state_nxt = vbch_pkg::ST_VOL;
      vbch_pkg::ST_VOL:      state_nxt = vbch_pkg::ST_OUT;
      vbch_pkg::ST_OUT:      if (out_free) state_nxt = vbch_pkg::ST_IDLE;
      default:               state_nxt = vbch_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mac_sel = vbch_pkg::MAC_SCALE;
    in_stall    = 1'b1;
    unique case (state_r)
      vbch_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      vbch_pkg::ST_SCALE: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_clr = 1'b1;
        cmd.mac_sel = vbch_pkg::MAC_SCALE;
      end
      vbch_pkg::ST_XREG:  cmd.x_wr = 1'b1;
      vbch_pkg::ST_ENV_A: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_clr = 1'b1;
        cmd.mac_sel = vbch_pkg::MAC_ENV_OLD;
      end
      vbch_pkg::ST_ENV_B: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = vbch_pkg::MAC_ENV_NEW;
      end
      vbch_pkg::ST_ENV_W: cmd.env_wr = 1'b1;
      vbch_pkg::ST_HARM_A: begin
        cmd.mac_en    = 1'b1;
        cmd.mac_clr   = 1'b1;
        cmd.mac_sel   = vbch_pkg::MAC_HARM_OLD;
        cmd.div_start = 1'b1;
      end
      vbch_pkg::ST_HARM_B: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = vbch_pkg::MAC_HARM_NEW;
      end
      vbch_pkg::ST_HARM_W:   cmd.harm_wr = 1'b1;
      vbch_pkg::ST_DIV_WAIT: ;
      vbch_pkg::ST_RATIO: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_clr = 1'b1;
        cmd.mac_sel = vbch_pkg::MAC_RATIO;
      end
      vbch_pkg::ST_GAIN: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = vbch_pkg::MAC_GAIN;
      end
      vbch_pkg::ST_SUM_W: cmd.sum_wr = 1'b1;
      vbch_pkg::ST_VOL: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_clr = 1'b1;
        cmd.mac_sel = vbch_pkg::MAC_VOL;
      end
      vbch_pkg::ST_OUT:   cmd.out_wr = out_free;
      default: ;
    endcase
  end

  always_comb begin
    priority if (cmd.out_wr) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vbch_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/virtual_bass_compressor_harmonics.sv
// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    in_data   (sample_in, last_in_block)
// out_      output     out_valid / out_stall  out_data  (sample_out, last_out)
// cfg_      input      cfg_we                 cfg_index, cfg_data
//
// one transaction at a time: from one accepted input to the next, most of the time
// goes to the 24-step restoring divider that forms the compression ratio
// the result sits in an output register, so a new input is taken while it waits
// a stalled result holds the last state before write-back until it is taken
// synchronous active-low reset restores the register defaults and clears both states
module virtual_bass_compressor_harmonics (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  vbch_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output vbch_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [vbch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vbch_pkg::COEF_W-1:0]     cfg_data
);

  vbch_pkg::dp_cmd_t cmd;
  vbch_pkg::dp_sts_t sts;

  vbch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  vbch_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  a_in_single : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction is in flight");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_wr |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  a_div_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

  a_out_div_done : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_wr |-> !sts.div_busy)
    else $error("result written before ratio ready");

endmodule
